// ===== src/bcl_pkg.sv =====
// Shared constants, codes and types of the blink code LED identifier.
`default_nettype none
package bcl_pkg;

    localparam int WIN_DEPTH    = 16;
    localparam int SAMPLE_W     = 16;
    localparam int CODE_W       = WIN_DEPTH;
    localparam int LEN_W        = $clog2(WIN_DEPTH + 1);
    localparam int PTR_W        = $clog2(WIN_DEPTH);
    localparam int MAX_PATTERNS = 64;
    localparam int PAT_IDX_W    = $clog2(MAX_PATTERNS);
    localparam int PAT_CNT_W    = $clog2(MAX_PATTERNS + 1);
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    typedef logic [2:0] t_status;
    localparam t_status STATUS_IDENTIFIED   = 3'd0;
    localparam t_status STATUS_TOO_FEW      = 3'd1;
    localparam t_status STATUS_LOW_CONTRAST = 3'd2;
    localparam t_status STATUS_NO_MATCH     = 3'd3;
    localparam t_status STATUS_STORED       = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CODE_LENGTH   = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_COUNT = 2'd1;
    localparam t_cfg_idx CFG_MIN_CONTRAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MATCH,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [CODE_W-1:0]    bits;
        logic [LEN_W-1:0]     len;
        logic [PAT_CNT_W-1:0] count;
    } t_match_req;

    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [PAT_IDX_W-1:0] id;
    } t_match_sts;

endpackage
`default_nettype wire

// ===== src/bcl_cell.sv =====
// One cell of the sample ring: holds a sample and thresholds it.
`default_nettype none
module bcl_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_shift,
    input  wire logic [bcl_pkg::SAMPLE_W-1:0]  i_data,
    input  wire logic [bcl_pkg::SAMPLE_W:0]    i_sum,
    output logic      [bcl_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                               o_bit
);
    import bcl_pkg::*;

    logic [SAMPLE_W-1:0] r_sample;

    // take the neighbor's sample on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_data;
        end
    end

    assign o_sample = r_sample;
    // lit when 2*sample >= min+max
    assign o_bit    = ({r_sample, 1'b0} >= i_sum);

endmodule
`default_nettype wire

// ===== src/bcl_match.sv =====
// Pattern table and rotation matcher, one stored word per cycle.
`default_nettype none
module bcl_match (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr,
    input  wire logic [bcl_pkg::PAT_IDX_W-1:0]  i_wr_idx,
    input  wire logic [bcl_pkg::CODE_W-1:0]     i_wr_bits,
    input  wire bcl_pkg::t_match_req            i_req,
    output bcl_pkg::t_match_sts                 o_sts
);
    import bcl_pkg::*;

    logic [CODE_W-1:0]    r_mem [MAX_PATTERNS];
    logic [CODE_W-1:0]    r_rd_data;
    logic [CODE_W-1:0]    r_rot [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] r_rot_ok;
    logic [CODE_W-1:0]    r_mask;
    logic [PAT_CNT_W-1:0] r_count;
    logic [PAT_CNT_W-1:0] r_rd_idx;
    logic [PAT_CNT_W-1:0] r_cmp_idx;
    logic                 r_cmp_valid;
    logic                 r_busy;

    logic [2*CODE_W-1:0]  w_dbl;
    logic [CODE_W:0]      w_mask_wide;
    logic [CODE_W-1:0]    w_want;
    logic                 w_hit;
    logic                 w_last;
    logic                 w_done;
    logic                 w_issue;

    // the code repeated twice: any rotation is a window of it
    assign w_dbl = ({{CODE_W{1'b0}}, i_req.bits} << i_req.len)
                 | {{CODE_W{1'b0}}, i_req.bits};
    assign w_mask_wide = ((CODE_W + 1)'(1) << i_req.len) - (CODE_W + 1)'(1);

    assign w_want = r_rd_data & r_mask;

    always_comb begin
        w_hit = 1'b0;
        for (int r = 0; r < WIN_DEPTH; r++) begin
            if (r_cmp_valid && r_rot_ok[r] && (r_rot[r] == w_want)) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_last  = r_cmp_valid && (r_cmp_idx == r_count - PAT_CNT_W'(1));
    assign w_done  = r_busy && (w_hit || w_last || (r_count == '0));
    assign w_issue = r_busy && !w_done && (r_rd_idx < r_count);

    assign o_sts.done  = w_done;
    assign o_sts.found = w_hit;
    assign o_sts.id    = r_cmp_idx[PAT_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_idx] <= i_wr_bits;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_idx[PAT_IDX_W-1:0]];
            r_cmp_idx <= r_rd_idx;
        end
        if (i_req.start) begin
            for (int r = 0; r < WIN_DEPTH; r++) begin
                r_rot[r]    <= w_dbl[r +: CODE_W] & w_mask_wide[CODE_W-1:0];
                r_rot_ok[r] <= (LEN_W'(r) < i_req.len);
            end
            r_mask  <= w_mask_wide[CODE_W-1:0];
            r_count <= i_req.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_rd_idx    <= '0;
        end else if (i_req.start) begin
            r_busy      <= 1'b1;
            r_cmp_valid <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            r_cmp_valid <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + PAT_CNT_W'(1);
            end
            if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/blink_code_led_identifier.sv =====
// Top level: sample ring of cells, control sequencer and pattern matcher.
// A pattern store or too few samples goes straight to the result; otherwise the ring
// pass runs, a contrast decision follows, and then the pattern table is searched.
// Throughput: one transaction at a time, set by the 16-step ring pass and one table word
// per cycle; the next is taken while a finished result waits in the output register.
// Reset (synchronous, active low) clears sample count, registers and output, not ring or table.
`default_nettype none
module blink_code_led_identifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire bcl_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [bcl_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_action,
    input  wire logic [bcl_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic [bcl_pkg::PAT_IDX_W-1:0]  i_pattern_index,
    input  wire logic [bcl_pkg::CODE_W-1:0]     i_pattern_bits,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bcl_pkg::t_status                    o_status,
    output logic      [bcl_pkg::PAT_IDX_W-1:0]  o_led_id
);
    import bcl_pkg::*;

    // configuration
    logic [LEN_W-1:0]     r_code_length;
    logic [PAT_CNT_W-1:0] r_pattern_count;
    logic [SAMPLE_W-1:0]  r_min_contrast;

    // control and datapath state
    t_state               r_state;
    t_state               n_state;
    logic [LEN_W-1:0]     r_seen;
    logic [PTR_W-1:0]     r_scan_cnt;
    logic [SAMPLE_W-1:0]  r_lo;
    logic [SAMPLE_W-1:0]  r_hi;
    t_status              r_res_status;
    logic [PAT_IDX_W-1:0] r_res_id;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [PAT_IDX_W-1:0] r_out_id;

    logic [LEN_W-1:0]     w_len;
    logic [PAT_CNT_W-1:0] w_count;
    logic [LEN_W-1:0]     w_seen_next;
    logic                 w_too_few;
    logic                 w_include;
    logic                 w_scan_last;
    logic                 w_low;
    logic [SAMPLE_W:0]    w_sum;
    logic [SAMPLE_W-1:0]  w_tail;
    logic [SAMPLE_W-1:0]  w_cell_val [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] w_cell_bit;
    logic [CODE_W-1:0]    w_rev;
    logic [CODE_W-1:0]    w_bits;

    logic                 w_accept;
    logic                 w_store;
    logic                 w_take_sample;
    logic                 w_scan;
    logic                 w_shift;
    logic                 w_emit;
    t_match_req           w_req;
    t_match_sts           w_sts;

    // clamp the registers into their working ranges
    always_comb begin
        if (r_code_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_code_length > LEN_W'(WIN_DEPTH)) begin
            w_len = LEN_W'(WIN_DEPTH);
        end else begin
            w_len = r_code_length;
        end
        if (r_pattern_count > PAT_CNT_W'(MAX_PATTERNS)) begin
            w_count = PAT_CNT_W'(MAX_PATTERNS);
        end else begin
            w_count = r_pattern_count;
        end
    end

    // saturating sample count, as it stands once this sample is in
    assign w_seen_next = (r_seen == LEN_W'(WIN_DEPTH)) ? r_seen : r_seen + LEN_W'(1);
    assign w_too_few   = (w_seen_next < w_len);

    // during the scan the tail cell shows the sample that sat at cell
    // WIN_DEPTH-1-k; keep it when that cell is among the newest len samples
    assign w_tail      = w_cell_val[WIN_DEPTH-1];
    assign w_include   = ({1'b0, r_scan_cnt} + w_len) >= LEN_W'(WIN_DEPTH);
    assign w_scan_last = (r_scan_cnt == PTR_W'(WIN_DEPTH - 1));
    assign w_low       = ((r_hi - r_lo) <= r_min_contrast);
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};

    // ring of cells: cell 0 takes the new sample, or the tail while scanning
    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
        logic [SAMPLE_W-1:0] w_in;
        if (g == 0) begin : g_head
            assign w_in = w_scan ? w_tail : i_sample;
        end else begin : g_body
            assign w_in = w_cell_val[g-1];
        end
        bcl_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_shift),
            .i_data   (w_in),
            .i_sum    (w_sum),
            .o_sample (w_cell_val[g]),
            .o_bit    (w_cell_bit[g])
        );
    end

    // cell 0 is the newest sample; bit 0 of the code is the oldest of the
    // last len samples, so reverse and drop the unused top
    always_comb begin
        for (int j = 0; j < CODE_W; j++) begin
            w_rev[j] = w_cell_bit[WIN_DEPTH-1-j];
        end
    end
    assign w_bits = w_rev >> (LEN_W'(WIN_DEPTH) - w_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_action || w_too_few) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = w_low ? ST_RESULT : ST_MATCH;
            end
            ST_MATCH: begin
                if (w_sts.done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        w_accept      = i_in_valid && (r_state == ST_IDLE);
        w_store       = w_accept && i_action;
        w_take_sample = w_accept && !i_action;
        w_scan        = (r_state == ST_SCAN);
        w_shift       = w_take_sample || w_scan;
        w_emit        = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);
        w_req.start   = (r_state == ST_DECIDE) && !w_low;
        w_req.bits    = w_bits;
        w_req.len     = w_len;
        w_req.count   = w_count;
    end

    bcl_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_store),
        .i_wr_idx  (i_pattern_index),
        .i_wr_bits (i_pattern_bits),
        .i_req     (w_req),
        .o_sts     (w_sts)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_seen          <= '0;
            r_scan_cnt      <= '0;
            r_out_valid     <= 1'b0;
            r_code_length   <= LEN_W'(WIN_DEPTH);
            r_pattern_count <= '0;
            r_min_contrast  <= SAMPLE_W'(128);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CODE_LENGTH:   r_code_length   <= i_cfg_data[LEN_W-1:0];
                    CFG_PATTERN_COUNT: r_pattern_count <= i_cfg_data[PAT_CNT_W-1:0];
                    CFG_MIN_CONTRAST:  r_min_contrast  <= i_cfg_data[SAMPLE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_take_sample) begin
                r_seen <= w_seen_next;
            end
            // restart the ring pass on each new sample, advance while scanning
            if (w_take_sample) begin
                r_scan_cnt <= '0;
            end else if (w_scan) begin
                r_scan_cnt <= r_scan_cnt + PTR_W'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take_sample) begin
            r_lo <= '1;
            r_hi <= '0;
        end else if (w_scan && w_include) begin
            if (w_tail < r_lo) begin
                r_lo <= w_tail;
            end
            if (w_tail > r_hi) begin
                r_hi <= w_tail;
            end
        end

        if (w_store) begin
            r_res_status <= STATUS_STORED;
            r_res_id     <= '0;
        end else if (w_take_sample && w_too_few) begin
            r_res_status <= STATUS_TOO_FEW;
            r_res_id     <= '0;
        end else if ((r_state == ST_DECIDE) && w_low) begin
            r_res_status <= STATUS_LOW_CONTRAST;
            r_res_id     <= '0;
        end else if ((r_state == ST_MATCH) && w_sts.done) begin
            r_res_status <= w_sts.found ? STATUS_IDENTIFIED : STATUS_NO_MATCH;
            r_res_id     <= w_sts.found ? w_sts.id : '0;
        end

        if (w_emit) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_led_id    = r_out_id;

endmodule
`default_nettype wire

// ===== src/bcl_checker.sv =====
// Port-level checks of the blink code LED identifier, bound to the top level.
`default_nettype none
module bcl_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire bcl_pkg::t_status               o_status,
    input wire logic [bcl_pkg::PAT_IDX_W-1:0]  o_led_id
);
    import bcl_pkg::*;

    // drop any result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // only an identified light carries an index
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STATUS_IDENTIFIED)) |-> (o_led_id == '0))
        else $error("led id set without identification");

    // one transaction at a time: input closes after each acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after acceptance");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= STATUS_STORED))
        else $error("status code out of range");

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_led_id)))
        else $error("stalled result changed");

endmodule

bind blink_code_led_identifier bcl_checker u_bcl_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the blink code LED identifier: directed and random traffic.
module testbench;
    import bcl_pkg::*;

    // One expected result: what the block reports for one accepted transaction.
    typedef struct {
        t_status              status;
        logic [PAT_IDX_W-1:0] led_id;
    } t_outcome;

    // Track the window, the code table and the registers; predict and check results.
    class led_id_scoreboard;
        logic [SAMPLE_W-1:0] window [WIN_DEPTH];
        logic [PTR_W-1:0]    wr_slot;
        logic [LEN_W-1:0]    seen;
        logic [CODE_W-1:0]   codes [MAX_PATTERNS];
        bit                  written [MAX_PATTERNS];
        logic [4:0]          code_length;
        logic [6:0]          pattern_count;
        logic [15:0]         min_contrast;
        t_outcome            pending_outcomes [$];
        int                  failures;

        function new();
            code_length   = 5'd16;
            pattern_count = 7'd0;
            min_contrast  = 16'd128;
            wr_slot       = '0;
            seen          = '0;
            failures      = 0;
            foreach (window[i]) window[i] = '0;
            foreach (codes[i]) begin
                codes[i]   = '0;
                written[i] = 1'b0;
            end
        endfunction

        // Zero means one frame; anything past the window depth is clipped.
        function int unsigned active_length();
            if (code_length == 0) return 1;
            if (code_length > WIN_DEPTH) return WIN_DEPTH;
            return code_length;
        endfunction

        function int unsigned active_count();
            return (pattern_count > MAX_PATTERNS) ? MAX_PATTERNS : pattern_count;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_CODE_LENGTH:   code_length   = data[4:0];
                CFG_PATTERN_COUNT: pattern_count = data[6:0];
                CFG_MIN_CONTRAST:  min_contrast  = data;
                default: ;
            endcase
        endfunction

        // Classify the newest frames: count, contrast, threshold, then table search.
        function t_outcome identify_window();
            t_outcome            res;
            int unsigned         len;
            logic [SAMPLE_W-1:0] vals [WIN_DEPTH];
            logic [SAMPLE_W-1:0] lo, hi;
            logic [SAMPLE_W:0]   mid_sum;
            logic [CODE_W:0]     mask_wide;
            logic [CODE_W-1:0]   mask, bits, rot, want;
            len        = active_length();
            res.status = STATUS_TOO_FEW;
            res.led_id = '0;
            if (seen < len) return res;
            // vals[0] is the oldest of the last len frames
            for (int i = 0; i < len; i++)
                vals[i] = window[(wr_slot + WIN_DEPTH - (len - i)) % WIN_DEPTH];
            lo = vals[0];
            hi = vals[0];
            for (int i = 1; i < len; i++) begin
                if (vals[i] < lo) lo = vals[i];
                if (vals[i] > hi) hi = vals[i];
            end
            if (hi - lo <= min_contrast) begin
                res.status = STATUS_LOW_CONTRAST;
                return res;
            end
            // lit when 2*sample >= min+max, exact at full width
            mid_sum   = {1'b0, lo} + {1'b0, hi};
            mask_wide = (17'd1 << len) - 17'd1;
            mask      = mask_wide[CODE_W-1:0];
            bits      = '0;
            for (int i = 0; i < len; i++)
                if ({vals[i], 1'b0} >= mid_sum) bits[i] = 1'b1;
            for (int p = 0; p < active_count(); p++) begin
                want = codes[p] & mask;
                rot  = bits;
                for (int r = 0; r < len; r++) begin
                    if (rot == want) begin
                        res.status = STATUS_IDENTIFIED;
                        res.led_id = PAT_IDX_W'(p);
                        return res;
                    end
                    rot = ((rot >> 1) | (CODE_W'(rot[0]) << (len - 1))) & mask;
                end
            end
            res.status = STATUS_NO_MATCH;
            return res;
        endfunction

        function void note_item(logic act, logic [SAMPLE_W-1:0] smp,
                                logic [PAT_IDX_W-1:0] slot, logic [CODE_W-1:0] code);
            t_outcome res;
            if (act) begin
                // a code store leaves the sample window alone
                codes[slot]   = code;
                written[slot] = 1'b1;
                res.status    = STATUS_STORED;
                res.led_id    = '0;
            end else begin
                window[wr_slot] = smp;
                wr_slot         = wr_slot + 1'b1;
                if (seen < WIN_DEPTH) seen = seen + 1'b1;
                res = identify_window();
            end
            pending_outcomes.insert(pending_outcomes.size(), res);
        endfunction

        function void check_result(t_status status, logic [PAT_IDX_W-1:0] led_id);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result status=%0d led_id=%0d with nothing pending",
                             status, led_id);
                return;
            end
            want = pending_outcomes[0];
            pending_outcomes.delete(0);
            if (status !== want.status || led_id !== want.led_id) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: expected status=%0d led_id=%0d, got status=%0d led_id=%0d",
                             want.status, want.led_id, status, led_id);
            end
        endfunction

        function void close_out();
            if (pending_outcomes.size() != 0) begin
                if (failures < 10)
                    $display("ERROR: %0d results never arrived", pending_outcomes.size());
                failures += pending_outcomes.size();
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_action;
    logic [SAMPLE_W-1:0]  i_sample;
    logic [PAT_IDX_W-1:0] i_pattern_index;
    logic [CODE_W-1:0]    i_pattern_bits;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_status              o_status;
    logic [PAT_IDX_W-1:0] o_led_id;

    led_id_scoreboard sb = new();
    int               items_sent;
    bit               quiet;        // no idling on either side while set
    int               hold_cycles;  // request for a long receiver hold-off

    always #2 i_clk = ~i_clk;

    blink_code_led_identifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_sample        (i_sample),
        .i_pattern_index (i_pattern_index),
        .i_pattern_bits  (i_pattern_bits),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_led_id        (o_led_id)
    );

    // Sample both handshakes at the edge; all values seen here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_in_valid && o_in_ready)
                sb.note_item(i_action, i_sample, i_pattern_index, i_pattern_bits);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_status, o_led_id);
        end
    end

    // Result side: random stalls, plus a long hold-off on request, counted here.
    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles - 1) @(posedge i_clk);
                hold_cycles = 0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // Offer one transaction; return at the edge that takes it, valid still high.
    task automatic offer(logic act, logic [SAMPLE_W-1:0] smp,
                         logic [PAT_IDX_W-1:0] slot, logic [CODE_W-1:0] code);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_sample        <= smp;
        i_pattern_index <= slot;
        i_pattern_bits  <= code;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
    endtask

    // Unused fields carry random bits so every input bit toggles.
    task automatic offer_sample(logic [SAMPLE_W-1:0] smp);
        offer(1'b0, smp, PAT_IDX_W'($urandom), CODE_W'($urandom));
    endtask

    task automatic offer_store(logic [PAT_IDX_W-1:0] slot, logic [CODE_W-1:0] code);
        offer(1'b1, SAMPLE_W'($urandom), slot, code);
    endtask

    // Write one register; the block must be idle.
    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Play a stored code (or a random one) around its cycle with clean lit/dark levels.
    task automatic send_blink_code();
        int unsigned       len, cnt, mc, d, j, lo_lvl, n, start, room;
        logic [CODE_W-1:0] code;
        len = sb.active_length();
        cnt = sb.active_count();
        mc  = sb.min_contrast;
        if (cnt != 0 && $urandom_range(0, 9) != 0)
            code = sb.codes[$urandom_range(0, cnt - 1)];
        else
            code = CODE_W'($urandom);
        if (mc >= 65535) begin
            d = 65535;
            j = 0;
        end else begin
            // half the time stay just above the contrast limit
            room = 65534 - mc;
            if (room > 255 && $urandom_range(0, 1)) room = 255;
            d = mc + 1 + $urandom_range(0, room);
            j = (d - mc - 1) / 2;
        end
        lo_lvl = $urandom_range(0, 65535 - d);
        n      = len + $urandom_range(0, len);
        start  = $urandom_range(0, len - 1);
        for (int k = 0; k < n; k++) begin
            if (code[(start + k) % len])
                offer_sample(SAMPLE_W'(lo_lvl + d - $urandom_range(0, j)));
            else
                offer_sample(SAMPLE_W'(lo_lvl));
        end
    endtask

    // Near-constant brightness, aimed at the low contrast case.
    task automatic send_steady_light();
        int unsigned base, span;
        base = $urandom_range(0, 65535);
        span = sb.min_contrast;
        if (span > 65535 - base) span = 65535 - base;
        if (span > 64) span = 64;
        repeat ($urandom_range(1, sb.active_length()))
            offer_sample(SAMPLE_W'(base + $urandom_range(0, span)));
    endtask

    initial begin
        int unsigned len_val, cnt_val, mc_val, sel, phase_end;
        int          phase;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_CODE_LENGTH;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_action        <= 1'b0;
        i_sample        <= '0;
        i_pattern_index <= '0;
        i_pattern_bits  <= '0;
        quiet       = 1'b0;
        hold_cycles = 0;
        items_sent  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stores at both table ends, then fill the window from empty.
        // The first 15 frames are too few; the 16th is searched against an empty table.
        offer_store(PAT_IDX_W'(0), 16'hAAAA);
        offer_store(PAT_IDX_W'(MAX_PATTERNS - 1), 16'h5555);
        for (int k = 0; k < WIN_DEPTH; k++)
            offer_sample(k[0] ? 16'hFFFF : 16'h0000);
        wait_for_results();

        // Code length zero acts as one frame, which is always steady light.
        // Upper data bits above each register's width are dropped.
        write_register(CFG_CODE_LENGTH, 16'hFFE0);
        write_register(CFG_PATTERN_COUNT, 16'hFF81);
        write_register(CFG_MIN_CONTRAST, 16'h0000);
        offer_sample(16'h1234);
        wait_for_results();

        // Oversized code length clips to the window; full-scale contrast limit.
        write_register(CFG_CODE_LENGTH, 16'h0031);
        write_register(CFG_MIN_CONTRAST, 16'hFFFF);
        offer_sample(16'hFFFF);
        wait_for_results();

        // Alternating frames now match entry 0, directly and rotated; a store in
        // the middle must not shift the window. Midscale counts as lit.
        write_register(CFG_MIN_CONTRAST, 16'h7FFE);
        offer_sample(16'h0000);
        offer_sample(16'hFFFF);
        offer_store(PAT_IDX_W'(5), 16'h1111);
        offer_sample(16'h0000);
        offer_sample(16'h8000);

        // Random phases: new settings, fill the searched part of the table, then traffic.
        phase = 0;
        while (items_sent < 925) begin
            wait_for_results();
            quiet = (phase == 1);
            sel = $urandom_range(0, 9);
            case (sel)
                0:       len_val = 0;
                1:       len_val = 1;
                2:       len_val = 2;
                3:       len_val = $urandom_range(17, 31);
                4, 5:    len_val = 16;
                default: len_val = $urandom_range(3, 15);
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0:       cnt_val = 0;
                1:       cnt_val = 64;
                2:       cnt_val = $urandom_range(65, 127);
                3:       cnt_val = $urandom_range(17, 63);
                default: cnt_val = $urandom_range(1, 16);
            endcase
            sel = $urandom_range(0, 9);
            case (sel)
                0:       mc_val = 0;
                1:       mc_val = 65535;
                2:       mc_val = $urandom_range(0, 65535);
                default: mc_val = $urandom_range(0, 3000);
            endcase
            write_register(CFG_CODE_LENGTH, CFG_W'(($urandom & 32'hFFE0) | len_val));
            write_register(CFG_PATTERN_COUNT, CFG_W'(($urandom & 32'hFF80) | cnt_val));
            write_register(CFG_MIN_CONTRAST, CFG_W'(mc_val));
            // never let a search reach an entry that was not written
            for (int p = 0; p < sb.active_count(); p++)
                if (!sb.written[p]) offer_store(PAT_IDX_W'(p), CODE_W'($urandom));
            // block the result side for a long stretch while traffic keeps coming
            if (phase == 2) hold_cycles = 400;
            phase_end = items_sent + $urandom_range(40, 120);
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    send_blink_code();
                else if (sel < 75)
                    offer_store(PAT_IDX_W'($urandom), CODE_W'($urandom));
                else if (sel < 90)
                    repeat ($urandom_range(1, 4)) offer_sample(SAMPLE_W'($urandom));
                else
                    send_steady_light();
            end
            phase++;
        end
        wait_for_results();
        quiet = 1'b0;
        repeat (100) @(posedge i_clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
